// ===== sv/srsw_pkg.sv =====
// shared types, codes and helpers for the selective-repeat sender window
`timescale 1ns / 1ps
`default_nettype none

package srsw_pkg;

  // fixed field widths
  localparam int SEQ_W     = 3;
  localparam int SEQ_SPACE = 8;
  localparam int MARK_W    = 4;
  localparam int DATA_W    = 64;
  localparam int OP_W      = 2;
  localparam int TMR_W     = 2;

  // event codes
  localparam logic [OP_W-1:0] OP_SEND    = 2'd0;
  localparam logic [OP_W-1:0] OP_ACK     = 2'd1;
  localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd2;

  // timer action codes
  localparam logic [TMR_W-1:0] TMR_NONE    = 2'd0;
  localparam logic [TMR_W-1:0] TMR_START   = 2'd1;
  localparam logic [TMR_W-1:0] TMR_STOP    = 2'd2;
  localparam logic [TMR_W-1:0] TMR_RESTART = 2'd3;

  // per-transaction result from the window control, payload aside
  typedef struct packed {
    logic             accepted;
    logic             emit;
    logic             use_ram;
    logic [SEQ_W-1:0] pseq;
    logic [TMR_W-1:0] taction;
    logic [SEQ_W-1:0] tseq;
    logic             full;
    logic [SEQ_W-1:0] base;
  } ctrl_t;

  // number of consecutive set bits starting at bit 0
  function automatic logic [SEQ_W-1:0] lead_ones(input logic [MARK_W-1:0] marks);
    logic [SEQ_W-1:0] cnt;
    logic             run;
    cnt = '0;
    run = 1'b1;
    for (int k = 0; k < MARK_W; k++) begin
      run = run & marks[k];
      if (run) cnt = cnt + SEQ_W'(1);
    end
    return cnt;
  endfunction

endpackage

`default_nettype wire

// ===== sv/selective_repeat_sender_window.sv =====
// top level of the selective-repeat sender window
//
// One input transaction per event: op selects send, acknowledgement or
// timer expiry; the other fields carry payload, ack number, checksum flag
// and expired sequence number. Every accepted transaction yields exactly one
// output transaction with the send verdict, any packet to emit, the timer
// action and the window state after the event.
// The result passes through stage 1, where the packet store read completes,
// and then the output register. Throughput: one event per cycle while the
// receiver does not stall; window state updates in the accepting cycle and
// the store is written on sends and read on resends through its single
// write and single read port, so events never wait on each other.
// Reset clears the window (base, next sequence, full flag, ack marks) and
// empties the pipeline; the packet store is not cleared. The user must see
// that no entry is read before a send has written it; the block does not
// enforce this. When the receiver stalls, the output register and the stage
// behind it fill and in_ready drops; nothing is lost, and flow resumes as
// soon as out_ready returns.
`timescale 1ns / 1ps
`default_nettype none

module selective_repeat_sender_window #(
  parameter int WINDOW       = 4,
  parameter int PAYLOAD_BITS = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [srsw_pkg::OP_W-1:0]   op,
  input  wire logic [srsw_pkg::DATA_W-1:0] payload_word,
  input  wire logic [srsw_pkg::SEQ_W-1:0]  ack_number,
  input  wire logic                        ack_check_ok,
  input  wire logic [srsw_pkg::SEQ_W-1:0]  expired_seq,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             accepted,
  output logic                             emit_packet,
  output logic [srsw_pkg::SEQ_W-1:0]       packet_seq,
  output logic [srsw_pkg::DATA_W-1:0]      packet_data,
  output logic [srsw_pkg::TMR_W-1:0]       timer_action,
  output logic [srsw_pkg::SEQ_W-1:0]       timer_seq,
  output logic                             window_full,
  output logic [srsw_pkg::SEQ_W-1:0]       window_base
);
  import srsw_pkg::*;

  logic                    fire;
  ctrl_t                   res;
  logic                    wr_en, rd_en;
  logic [SEQ_W-1:0]        wr_addr, rd_addr;
  logic [PAYLOAD_BITS-1:0] payload_trim;
  logic [PAYLOAD_BITS-1:0] ram_rd_data;

  logic                    s1_valid;
  ctrl_t                   s1_res;
  logic [PAYLOAD_BITS-1:0] s1_data;
  logic                    out_load;
  logic                    s1_advance;
  logic [PAYLOAD_BITS-1:0] data_sel;

  // handshake
  assign out_load     = !out_valid || out_ready;
  assign s1_advance   = s1_valid && out_load;
  assign in_ready     = !s1_valid || out_load;
  assign fire         = in_valid && in_ready;
  assign payload_trim = payload_word[PAYLOAD_BITS-1:0];

  srsw_ctrl #(
    .WINDOW(WINDOW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .op          (op),
    .ack_number  (ack_number),
    .ack_check_ok(ack_check_ok),
    .expired_seq (expired_seq),
    .res         (res),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr)
  );

  srsw_ram #(
    .WIDTH(PAYLOAD_BITS),
    .DEPTH(SEQ_SPACE)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(payload_trim),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(ram_rd_data)
  );

  // stage 1: decision waits for the store read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (fire) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s1_res  <= res;
      s1_data <= res.accepted ? payload_trim : '0;
    end
  end

  // packet data source
  assign data_sel = s1_res.use_ram ? ram_rd_data : s1_data;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      accepted     <= s1_res.accepted;
      emit_packet  <= s1_res.emit;
      packet_seq   <= s1_res.pseq;
      packet_data  <= DATA_W'(data_sel);
      timer_action <= s1_res.taction;
      timer_seq    <= s1_res.tseq;
      window_full  <= s1_res.full;
      window_base  <= s1_res.base;
    end
  end

  // a taken send always emits and starts its timer
  a_send_starts: assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted |-> emit_packet && (timer_action == TMR_START))
    else $error("accepted send without emit and timer start");

  // every resend restarts the timer of the same packet
  a_restart_emits: assert property (@(posedge clk) disable iff (rst)
    out_valid && (timer_action == TMR_RESTART) |-> emit_packet && (packet_seq == timer_seq))
    else $error("timer restart without matching packet emit");

  // input is refused only while both stages are occupied and stalled
  a_ready_low: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && out_valid && !out_ready)
    else $error("input stalled with room in the pipeline");

  // an advancing stage 1 always lands in the output register
  a_advance: assert property (@(posedge clk) disable iff (rst)
    s1_advance |=> out_valid)
    else $error("stage 1 transaction lost");

endmodule

`default_nettype wire

// ===== sv/srsw_ram.sv =====
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module srsw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== sv/srsw_ctrl.sv =====
// window state and per-event decision for the selective-repeat sender
`timescale 1ns / 1ps
`default_nettype none

module srsw_ctrl #(
  parameter int WINDOW = 4
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      fire,
  input  wire logic [srsw_pkg::OP_W-1:0]  op,
  input  wire logic [srsw_pkg::SEQ_W-1:0] ack_number,
  input  wire logic                      ack_check_ok,
  input  wire logic [srsw_pkg::SEQ_W-1:0] expired_seq,
  output srsw_pkg::ctrl_t                res,
  output logic                           wr_en,
  output logic [srsw_pkg::SEQ_W-1:0]      wr_addr,
  output logic                           rd_en,
  output logic [srsw_pkg::SEQ_W-1:0]      rd_addr
);
  import srsw_pkg::*;

  localparam logic [SEQ_W-1:0] WIN_SEQ = SEQ_W'(WINDOW);

  logic [SEQ_W-1:0]  base_seq, base_seq_next;
  logic [SEQ_W-1:0]  next_seq, next_seq_next;
  logic              full_flag, full_flag_next;
  logic [MARK_W-1:0] acked_marks, acked_marks_next;

  logic [SEQ_W-1:0]  outstanding;
  logic [SEQ_W-1:0]  seq_inc;
  logic [SEQ_W-1:0]  ack_dist;
  logic [MARK_W-1:0] marks_or;
  logic [SEQ_W-1:0]  lead;
  logic              ack_good;

  // window arithmetic
  always_comb begin
    outstanding = next_seq - base_seq;
    seq_inc     = next_seq + SEQ_W'(1);
    ack_dist    = ack_number - base_seq;
    marks_or    = acked_marks | (MARK_W'(1) << ack_dist);
    lead        = lead_ones(marks_or);
    ack_good    = ack_check_ok && (ack_dist < WIN_SEQ) && (ack_dist < outstanding);
  end

  // event decision
  always_comb begin
    base_seq_next    = base_seq;
    next_seq_next    = next_seq;
    full_flag_next   = full_flag;
    acked_marks_next = acked_marks;
    res              = '0;
    wr_en            = 1'b0;
    wr_addr          = next_seq;
    rd_en            = 1'b0;
    rd_addr          = base_seq;
    case (op)
      OP_SEND: begin
        if (!full_flag) begin
          wr_en         = fire;
          res.accepted  = 1'b1;
          res.emit      = 1'b1;
          res.pseq      = next_seq;
          res.taction   = TMR_START;
          res.tseq      = next_seq;
          next_seq_next = seq_inc;
          if ((seq_inc - base_seq) == WIN_SEQ) full_flag_next = 1'b1;
        end
      end
      OP_ACK: begin
        if (ack_good) begin
          res.taction = TMR_STOP;
          res.tseq    = ack_number;
          if (ack_dist == '0) begin
            base_seq_next    = base_seq + lead;
            full_flag_next   = 1'b0;
            acked_marks_next = marks_or >> lead;
          end else begin
            acked_marks_next = marks_or;
          end
        end else if (outstanding != '0) begin
          rd_en       = fire;
          rd_addr     = base_seq;
          res.emit    = 1'b1;
          res.use_ram = 1'b1;
          res.pseq    = base_seq;
          res.taction = TMR_RESTART;
          res.tseq    = base_seq;
        end
      end
      OP_TIMEOUT: begin
        rd_en       = fire;
        rd_addr     = expired_seq;
        res.emit    = 1'b1;
        res.use_ram = 1'b1;
        res.pseq    = expired_seq;
        res.taction = TMR_RESTART;
        res.tseq    = expired_seq;
      end
      default: begin
      end
    endcase
    res.full = full_flag_next;
    res.base = base_seq_next;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_seq    <= '0;
      next_seq    <= '0;
      full_flag   <= 1'b0;
      acked_marks <= '0;
    end else if (fire) begin
      base_seq    <= base_seq_next;
      next_seq    <= next_seq_next;
      full_flag   <= full_flag_next;
      acked_marks <= acked_marks_next;
    end
  end

endmodule

`default_nettype wire
